FILE: rtl/core/lcdc_pkg.sv
// Package for the truth-table cover definedness check: item types, codes and helpers.
package lcdc_pkg;

	// Default and fixed sizes.
	localparam int MaxVarsDefault = 6;
	localparam int VarW           = 6;
	localparam int TableSize      = 64;
	localparam int CountW         = 7;
	localparam int VcW            = 3;
	localparam int MinVars        = 3;

	// Item function codes.
	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_ADD   = 1'b1
	} func_t;

	// Input transaction payload.
	typedef struct packed {
		func_t             func;
		logic [VcW-1:0]    var_count;
		logic [VarW-1:0]   sign_bits;
		logic [VarW-1:0]   care_bits;
	} in_item_t;

	// Result transaction payload.
	typedef struct packed {
		logic                 defined;
		logic [VcW-1:0]       pivot_var;
		logic [CountW-1:0]    cover_count;
		logic [TableSize-1:0] cover_bits;
	} out_item_t;

	// Positions that lie inside a table of 2^n entries.
	function automatic logic [TableSize-1:0] table_mask(input logic [VcW-1:0] n);
		logic [TableSize-1:0] m;
		m = '0;
		for (int p = 0; p < TableSize; p++) begin
			m[p] = ((VarW'(p) >> n) == '0);
		end
		return m;
	endfunction

	// Positions whose bit i is clear.
	function automatic logic [TableSize-1:0] lower_half_mask(input int i);
		logic [TableSize-1:0] m;
		m = '0;
		for (int p = 0; p < TableSize; p++) begin
			m[p] = (((p >> i) & 1) == 0);
		end
		return m;
	endfunction

	// Number of marked positions.
	function automatic logic [CountW-1:0] pop_count(input logic [TableSize-1:0] v);
		logic [CountW-1:0] c;
		c = '0;
		for (int p = 0; p < TableSize; p++) begin
			c = c + CountW'(v[p]);
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/lut_cover_definedness_check.sv
// Truth-table cover accumulator with a per-transaction definedness check.
//
//  Channel | Signals                       | Payload type
//  --------+-------------------------------+----------------------
//  input   | in_valid, in_ready, in_data   | lcdc_pkg::in_item_t
//  output  | out_valid, out_ready, out_data| lcdc_pkg::out_item_t
//
// One transaction is accepted per cycle unless the pipeline stalls; its result passes
// through the input register, then the cover update register, then the result register.
// The cover register is updated once per accepted transaction.
// Reset clears the cover and the stage valid flags and sets the variable count to MAX_VARS.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output still lets the earlier stages fill.
module lut_cover_definedness_check #(
	parameter int MAX_VARS = lcdc_pkg::MaxVarsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lcdc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lcdc_pkg::out_item_t out_data
);

	localparam int VcW  = lcdc_pkg::VcW;
	localparam int VarW = lcdc_pkg::VarW;
	localparam int TblN = lcdc_pkg::TableSize;
	localparam int CntW = lcdc_pkg::CountW;

	// Pipeline registers and state.
	logic                valid_s1, valid_s2, valid_s3;
	lcdc_pkg::in_item_t  item_s1;
	logic [TblN-1:0]     cover_s2;
	logic [VcW-1:0]      active_s2;
	lcdc_pkg::out_item_t res_s3;
	logic [TblN-1:0]     cover_q;
	logic [VcW-1:0]      active_q;

	// Stage advance controls.
	logic adv_s3, adv_s2, update;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign in_ready = !valid_s1 || adv_s2;
	assign update   = adv_s2 && valid_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Next cover: a start marks one position, an add expands the cube.
	logic [VcW-1:0]  vc_clamped, active_nxt;
	logic [VarW-1:0] low_mask, care_m, start_pos;
	logic [TblN-1:0] tbl_m, cover_nxt;

	always_comb begin
		if (item_s1.var_count < VcW'(lcdc_pkg::MinVars)) begin
			vc_clamped = VcW'(lcdc_pkg::MinVars);
		end else if (item_s1.var_count > VcW'(MAX_VARS)) begin
			vc_clamped = VcW'(MAX_VARS);
		end else begin
			vc_clamped = item_s1.var_count;
		end
		active_nxt = (item_s1.func == lcdc_pkg::FUNC_START) ? vc_clamped : active_q;
		low_mask   = ~({VarW{1'b1}} << active_nxt);
		care_m     = item_s1.care_bits & low_mask;
		start_pos  = item_s1.sign_bits & low_mask;
		tbl_m      = lcdc_pkg::table_mask(active_nxt);
		cover_nxt  = cover_q;
		for (int p = 0; p < TblN; p++) begin
			if (item_s1.func == lcdc_pkg::FUNC_START) begin
				cover_nxt[p] = (start_pos == VarW'(p));
			end else if (tbl_m[p] && (((VarW'(p) ^ item_s1.sign_bits) & care_m) == '0)) begin
				cover_nxt[p] = 1'b1;
			end
		end
	end

	// Cover state and second stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_q  <= '0;
			active_q <= VcW'(MAX_VARS);
			valid_s2 <= 1'b0;
		end else begin
			if (update) begin
				cover_q  <= cover_nxt;
				active_q <= active_nxt;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			cover_s2  <= cover_nxt;
			active_s2 <= active_nxt;
		end
	end

	// Count and definedness search over the variables.
	logic [CntW-1:0] count_s2;
	logic            def_s2;
	logic [VcW-1:0]  pivot_s2;
	logic [TblN-1:0] tbl_s2, closed, need;

	always_comb begin
		count_s2 = lcdc_pkg::pop_count(cover_s2);
		tbl_s2   = lcdc_pkg::table_mask(active_s2);
		def_s2   = 1'b0;
		pivot_s2 = '0;
		closed   = '0;
		need     = '0;
		if (count_s2 >= (CntW'(1) << (active_s2 >> 1))) begin
			for (int i = 0; i < VarW; i++) begin
				closed = cover_s2 | (cover_s2 >> (1 << i));
				need   = lcdc_pkg::lower_half_mask(i) & tbl_s2;
				if (!def_s2 && (VcW'(i) < active_s2) && ((closed & need) == need)) begin
					def_s2   = 1'b1;
					pivot_s2 = VcW'(i);
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			res_s3.defined     <= def_s2;
			res_s3.pivot_var   <= pivot_s2;
			res_s3.cover_count <= count_s2;
			res_s3.cover_bits  <= cover_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = res_s3;

	// The cover never holds positions outside the current table.
	a_cover_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cover_q & ~lcdc_pkg::table_mask(active_q)) == '0)
		else $error("cover holds a position outside the table");

	// The latched variable count stays within its clamped range.
	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q >= VcW'(lcdc_pkg::MinVars) && active_q <= VcW'(MAX_VARS))
		else $error("variable count out of range");

	// An add transaction never removes a marked position.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		update && item_s1.func == lcdc_pkg::FUNC_ADD
		|=> (cover_q & $past(cover_q)) == $past(cover_q))
		else $error("add transaction cleared a position");

	// A defined cover needs at least two marked positions.
	a_defined_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.defined |-> out_data.cover_count >= CntW'(2))
		else $error("defined reported with too few positions");

	// No pivot is named when the cover is not defined.
	a_pivot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.defined |-> out_data.pivot_var == '0)
		else $error("pivot named without definedness");

endmodule
